// File: rtl/core/sbde_pkg.sv
// Shared types and constants for the serial bus device byte engine.
// No dependencies; every module of the engine imports this package.
package sbde_pkg;

  localparam logic [7:0] EOI_TIMEOUT_RST = 8'd230;
  localparam logic [7:0] BIT_DELAY_RST   = 8'd100;
  localparam logic [7:0] TIMER_MAX       = 8'hFF;

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 16;

  typedef enum logic [0:0] {
    CFG_EOI_TIMEOUT = 1'b0,
    CFG_BIT_DELAY   = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    CMD_LISTEN     = 2'd0,
    CMD_TALK       = 2'd1,
    CMD_RELEASE    = 2'd2,
    CMD_TURN_REL   = 2'd3
  } mode_t;

  typedef enum logic [4:0] {
    PH_L_CLKHI    = 5'd0,
    PH_L_DATAHI   = 5'd1,
    PH_L_TALKER   = 5'd2,
    PH_L_EOIACK   = 5'd3,
    PH_L_EOICLKLO = 5'd4,
    PH_L_BITHI    = 5'd5,
    PH_L_BITLO    = 5'd6,
    PH_IDLE       = 5'd7,
    PH_TA_ATN     = 5'd8,
    PH_TA_CLK     = 5'd9,
    PH_TA_DELAY   = 5'd10,
    PH_RA_ATN     = 5'd11,
    PH_RA_CLK     = 5'd12,
    PH_RA_DELAY   = 5'd13,
    PH_RELEASED   = 5'd14,
    PH_T_START    = 5'd15,
    PH_T_EOILO    = 5'd16,
    PH_T_EOIHI    = 5'd17,
    PH_T_D1       = 5'd18,
    PH_T_D2       = 5'd19,
    PH_T_ACK      = 5'd20,
    PH_T_REL      = 5'd21,
    PH_ATN_WAIT   = 5'd22
  } phase_t;

  // One sample tick as seen by the engine.
  typedef struct packed {
    logic       atn_line;
    logic       clk_line;
    logic       data_line;
    logic       cmd_valid;
    mode_t      mode;
    logic [7:0] cmd_byte;
    logic       cmd_eoi;
  } tick_in_t;

  // Result of one tick: line drives plus report flags.
  typedef struct packed {
    logic       tx_done;
    logic       rx_break;
    logic       rx_eoi;
    logic       rx_atn;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       cmd_ready;
    logic       data_drive;
    logic       clk_drive;
  } tick_out_t;

  // Status from the engine used for checking at the top level.
  typedef struct packed {
    logic atn_edge;
    logic idle;
  } eng_status_t;

endpackage

// File: rtl/core/serial_bus_device_byte_engine.sv
// Top level of the serial bus device byte engine: stream ports, config port,
// protocol engine and output register. Depends on sbde_pkg, sbde_engine and
// sbde_out_buf.

// Each request on the input stream is one sample tick of the ATN, CLK and
// DATA lines with an optional host command, and yields exactly one result
// carrying the line drive levels and any report. A tick is fully processed
// by the protocol state machine and lands in a one-deep output register, so
// one request is accepted every cycle while the result side keeps up.
// Configuration writes are accepted in any cycle and should only be issued
// while the engine is idle.
module serial_bus_device_byte_engine
  import sbde_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // s_axis-style input; tdata from bit 0: atn_line, clk_line, data_line,
  // cmd_valid, cmd_byte[7:0], cmd_eoi, three zero bits.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // tuser: mode[1:0].
  input  logic [IN_USER_W-1:0]  in_tuser,
  // Result stream; tdata from bit 0: clk_drive, data_drive, cmd_ready,
  // rx_valid, rx_byte[7:0], rx_atn, rx_eoi, rx_break, tx_done.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [7:0]            cfg_data
);

  tick_in_t    tick_in;
  tick_out_t   tick_out;
  eng_status_t status;
  logic        can_load;
  logic        in_acc;

  assign tick_in.atn_line  = in_tdata[0];
  assign tick_in.clk_line  = in_tdata[1];
  assign tick_in.data_line = in_tdata[2];
  assign tick_in.cmd_valid = in_tdata[3];
  assign tick_in.cmd_byte  = in_tdata[11:4];
  assign tick_in.cmd_eoi   = in_tdata[12];
  assign tick_in.mode      = mode_t'(in_tuser);

  assign in_tready = can_load;
  assign in_acc    = in_tvalid & can_load;
  assign cfg_ready = 1'b1;

  sbde_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (in_acc),
    .tick_in   (tick_in),
    .cfg_wr    (cfg_valid),
    .cfg_idx   (cfg_index_t'(cfg_index)),
    .cfg_wdata (cfg_data),
    .tick_out  (tick_out),
    .status    (status)
  );

  sbde_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_tvalid),
    .res        (tick_out),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTHESIS
  a_atn_edge_drive: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && status.atn_edge |=> out_tvalid && !out_tdata[1] && out_tdata[0])
    else $error("attention edge did not pull data low and release clock");

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_tdata[2] == ($past(status.idle) && !$past(status.atn_edge)))
    else $error("command ready does not follow the idle phase");

  a_one_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> !out_tdata[2] && !(out_tdata[14] && out_tdata[15]))
    else $error("report overlaps command ready or carries two kinds");

  a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (!out_tdata[3] || out_tdata[14] || out_tdata[15])
      |-> out_tdata[13:4] == '0)
    else $error("byte fields set without a received byte report");
`endif

endmodule

// File: rtl/core/sbde_engine.sv
// Bus protocol state machine, tick timer, shift register and config registers.
// Depends on sbde_pkg; advances one step per accepted sample tick.
module sbde_engine
  import sbde_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  tick_in_t    tick_in,
  input  logic        cfg_wr,
  input  cfg_index_t  cfg_idx,
  input  logic [7:0]  cfg_wdata,
  output tick_out_t   tick_out,
  output eng_status_t status
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] timer_r, timer_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [3:0] bit_idx_r, bit_idx_nxt;
  logic       talking_r, talking_nxt;
  logic       eoi_r, eoi_nxt;
  logic       atnf_r, atnf_nxt;
  logic       atn_prev_r;
  logic       clk_lvl_r, clk_lvl_nxt;
  logic       dat_lvl_r, dat_lvl_nxt;
  logic [7:0] eoi_tmo_r;
  logic [7:0] bit_dly_r;

  logic       atn_edge;
  logic [7:0] timer_inc;
  logic [3:0] bit_idx_inc;
  logic       dly_done;

  assign atn_edge    = atn_prev_r & ~tick_in.atn_line;
  assign timer_inc   = (timer_r == TIMER_MAX) ? timer_r : timer_r + 8'd1;
  assign bit_idx_inc = bit_idx_r + 4'd1;
  assign dly_done    = (timer_inc >= bit_dly_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eoi_tmo_r <= EOI_TIMEOUT_RST;
      bit_dly_r <= BIT_DELAY_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        CFG_EOI_TIMEOUT: eoi_tmo_r <= cfg_wdata;
        CFG_BIT_DELAY:   bit_dly_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_L_CLKHI;
      timer_r    <= '0;
      shift_r    <= '0;
      bit_idx_r  <= '0;
      talking_r  <= 1'b0;
      eoi_r      <= 1'b0;
      atnf_r     <= 1'b0;
      atn_prev_r <= 1'b1;
      clk_lvl_r  <= 1'b1;
      dat_lvl_r  <= 1'b1;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      timer_r    <= timer_nxt;
      shift_r    <= shift_nxt;
      bit_idx_r  <= bit_idx_nxt;
      talking_r  <= talking_nxt;
      eoi_r      <= eoi_nxt;
      atnf_r     <= atnf_nxt;
      atn_prev_r <= tick_in.atn_line;
      clk_lvl_r  <= clk_lvl_nxt;
      dat_lvl_r  <= dat_lvl_nxt;
    end
  end

  // Next state.
  always_comb begin
    phase_nxt   = phase_r;
    timer_nxt   = timer_r;
    shift_nxt   = shift_r;
    bit_idx_nxt = bit_idx_r;
    talking_nxt = talking_r;
    eoi_nxt     = eoi_r;
    atnf_nxt    = atnf_r;
    clk_lvl_nxt = clk_lvl_r;
    dat_lvl_nxt = dat_lvl_r;
    if (atn_edge) begin
      dat_lvl_nxt = 1'b0;
      clk_lvl_nxt = 1'b1;
      phase_nxt   = PH_ATN_WAIT;
    end else begin
      case (phase_r)
        PH_L_CLKHI: begin
          if (tick_in.clk_line) begin
            atnf_nxt    = ~tick_in.atn_line;
            dat_lvl_nxt = 1'b1;
            phase_nxt   = PH_L_DATAHI;
          end
        end
        PH_L_DATAHI: begin
          if (tick_in.data_line) begin
            timer_nxt = '0;
            phase_nxt = PH_L_TALKER;
          end
        end
        PH_L_TALKER: begin
          timer_nxt = timer_inc;
          if (timer_inc > eoi_tmo_r) begin
            eoi_nxt     = 1'b1;
            dat_lvl_nxt = 1'b0;
            timer_nxt   = '0;
            phase_nxt   = PH_L_EOIACK;
          end else if (!tick_in.clk_line) begin
            bit_idx_nxt = '0;
            phase_nxt   = PH_L_BITHI;
          end
        end
        PH_L_EOIACK: begin
          timer_nxt = timer_inc;
          if (dly_done) begin
            dat_lvl_nxt = 1'b1;
            phase_nxt   = PH_L_EOICLKLO;
          end
        end
        PH_L_EOICLKLO: begin
          if (!tick_in.clk_line) begin
            bit_idx_nxt = '0;
            phase_nxt   = PH_L_BITHI;
          end
        end
        PH_L_BITHI: begin
          if (tick_in.clk_line) begin
            shift_nxt = {tick_in.data_line, shift_r[7:1]};
            phase_nxt = PH_L_BITLO;
          end
        end
        PH_L_BITLO: begin
          if (!tick_in.clk_line) begin
            bit_idx_nxt = bit_idx_inc;
            if (bit_idx_inc[3]) begin
              dat_lvl_nxt = 1'b0;
              phase_nxt   = PH_IDLE;
            end else begin
              phase_nxt = PH_L_BITHI;
            end
          end
        end
        PH_IDLE: begin
          if (tick_in.cmd_valid) begin
            case (tick_in.mode)
              CMD_LISTEN: begin
                eoi_nxt     = 1'b0;
                atnf_nxt    = 1'b0;
                shift_nxt   = '0;
                bit_idx_nxt = '0;
                timer_nxt   = '0;
                phase_nxt   = PH_L_CLKHI;
              end
              CMD_RELEASE: begin
                clk_lvl_nxt = 1'b1;
                dat_lvl_nxt = 1'b1;
                phase_nxt   = PH_RELEASED;
              end
              CMD_TURN_REL: phase_nxt = PH_RA_ATN;
              default: begin
                shift_nxt = tick_in.cmd_byte;
                eoi_nxt   = tick_in.cmd_eoi;
                if (talking_r) begin
                  clk_lvl_nxt = 1'b1;
                  phase_nxt   = PH_T_START;
                end else begin
                  talking_nxt = 1'b1;
                  phase_nxt   = PH_TA_ATN;
                end
              end
            endcase
          end
        end
        PH_TA_ATN: begin
          if (tick_in.atn_line) phase_nxt = PH_TA_CLK;
        end
        PH_RA_ATN: begin
          if (tick_in.atn_line) phase_nxt = PH_RA_CLK;
        end
        PH_TA_CLK, PH_RA_CLK: begin
          if (tick_in.clk_line) begin
            dat_lvl_nxt = 1'b1;
            clk_lvl_nxt = 1'b0;
            timer_nxt   = '0;
            phase_nxt   = (phase_r == PH_TA_CLK) ? PH_TA_DELAY : PH_RA_DELAY;
          end
        end
        PH_TA_DELAY: begin
          timer_nxt = timer_inc;
          if (dly_done) begin
            clk_lvl_nxt = 1'b1;
            phase_nxt   = PH_T_START;
          end
        end
        PH_RA_DELAY: begin
          timer_nxt = timer_inc;
          if (dly_done) begin
            clk_lvl_nxt = 1'b1;
            dat_lvl_nxt = 1'b1;
            phase_nxt   = PH_RELEASED;
          end
        end
        PH_T_START: begin
          if (tick_in.data_line) begin
            if (eoi_r) begin
              phase_nxt = PH_T_EOILO;
            end else begin
              clk_lvl_nxt = 1'b0;
              bit_idx_nxt = '0;
              timer_nxt   = '0;
              phase_nxt   = PH_T_D1;
            end
          end
        end
        PH_T_EOILO: begin
          if (!tick_in.data_line) phase_nxt = PH_T_EOIHI;
        end
        PH_T_EOIHI: begin
          if (tick_in.data_line) begin
            clk_lvl_nxt = 1'b0;
            bit_idx_nxt = '0;
            timer_nxt   = '0;
            phase_nxt   = PH_T_D1;
          end
        end
        PH_T_D1: begin
          timer_nxt = timer_inc;
          if (dly_done) begin
            dat_lvl_nxt = shift_r[0];
            clk_lvl_nxt = 1'b1;
            timer_nxt   = '0;
            phase_nxt   = PH_T_D2;
          end
        end
        PH_T_D2: begin
          timer_nxt = timer_inc;
          if (dly_done) begin
            clk_lvl_nxt = 1'b0;
            dat_lvl_nxt = 1'b1;
            shift_nxt   = {1'b0, shift_r[7:1]};
            bit_idx_nxt = bit_idx_inc;
            timer_nxt   = '0;
            phase_nxt   = bit_idx_inc[3] ? PH_T_ACK : PH_T_D1;
          end
        end
        PH_T_ACK: begin
          if (!tick_in.data_line) begin
            clk_lvl_nxt = 1'b0;
            phase_nxt   = eoi_r ? PH_T_REL : PH_IDLE;
          end
        end
        PH_T_REL: begin
          if (tick_in.data_line) phase_nxt = PH_IDLE;
        end
        PH_ATN_WAIT: begin
          if (!tick_in.clk_line) begin
            talking_nxt = 1'b0;
            eoi_nxt     = 1'b0;
            atnf_nxt    = 1'b0;
            shift_nxt   = '0;
            bit_idx_nxt = '0;
            timer_nxt   = '0;
            phase_nxt   = PH_L_CLKHI;
          end
        end
        default: ;
      endcase
    end
  end

  // Reports and line drives.
  always_comb begin
    tick_out            = '0;
    tick_out.clk_drive  = clk_lvl_nxt;
    tick_out.data_drive = dat_lvl_nxt;
    if (!atn_edge) begin
      case (phase_r)
        PH_IDLE: tick_out.cmd_ready = 1'b1;
        PH_L_BITLO: begin
          if (!tick_in.clk_line && bit_idx_inc[3]) begin
            tick_out.rx_valid = 1'b1;
            tick_out.rx_byte  = shift_r;
            tick_out.rx_atn   = atnf_r;
            tick_out.rx_eoi   = eoi_r;
          end
        end
        PH_T_ACK: begin
          if (!tick_in.data_line && !eoi_r) begin
            tick_out.rx_valid = 1'b1;
            tick_out.tx_done  = 1'b1;
          end
        end
        PH_T_REL: begin
          if (tick_in.data_line) begin
            tick_out.rx_valid = 1'b1;
            tick_out.tx_done  = 1'b1;
          end
        end
        PH_ATN_WAIT: begin
          if (!tick_in.clk_line) begin
            tick_out.rx_valid = 1'b1;
            tick_out.rx_break = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign status.atn_edge = atn_edge;
  assign status.idle     = (phase_r == PH_IDLE);

endmodule

// File: rtl/core/sbde_out_buf.sv
// Output register of the result stream; takes a new result whenever the
// register is empty or being drained. Depends on sbde_pkg.
module sbde_out_buf
  import sbde_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  tick_out_t             res,
  output logic                  can_load,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic                  vld_r;
  logic [OUT_DATA_W-1:0] data_r;

  assign can_load = ~vld_r | out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (can_load) begin
      vld_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      data_r <= res;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;

endmodule
